[hw/rtl/hpf_pkg.sv]
// Shared types and constants of the haptic PD force block.
// Used by every module of the block; depends on nothing.
package hpf_pkg;

  localparam int unsigned WindowDflt = 20;

  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdProxy = 2'd1;
  localparam logic [1:0] CmdRow   = 2'd2;

  localparam logic [1:0] CfgStiffness = 2'd0;
  localparam logic [1:0] CfgDamping   = 2'd1;
  localparam logic [1:0] CfgLimit     = 2'd2;

  typedef enum logic [1:0] {
    KindTick  = 2'd0,
    KindProxy = 2'd1,
    KindRow   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         row_select;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] mean_vel_x;
    logic signed [31:0] mean_vel_y;
    logic signed [31:0] mean_vel_z;
    logic               clamped;
  } out_item_t;

  typedef struct packed {
    logic [31:0] stiffness_gain;
    logic [31:0] damping_gain;
    logic [23:0] force_limit;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [1:0]       row;
    logic [2:0][31:0] first;
    logic [2:0][31:0] vel;
  } job_t;

endpackage

[hw/rtl/hpf_front.sv]
// Front end: accepts input beats, classifies them and queues the useful ones.
// Depends on hpf_pkg.
module hpf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  hpf_pkg::in_item_t in_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output hpf_pkg::job_t     job_o
);

  hpf_pkg::job_t slot_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  hpf_pkg::job_t job;
  logic          keep;
  logic          do_push, do_pop;

  // Classify; drop unused commands and writes to a row that does not exist.
  always_comb begin
    job.row   = in_i.row_select;
    job.first = {in_i.first_z, in_i.first_y, in_i.first_x};
    job.vel   = {in_i.vel_z, in_i.vel_y, in_i.vel_x};
    job.kind  = hpf_pkg::KindTick;
    keep      = 1'b1;
    unique case (in_i.command)
      hpf_pkg::CmdTick:  job.kind = hpf_pkg::KindTick;
      hpf_pkg::CmdProxy: job.kind = hpf_pkg::KindProxy;
      hpf_pkg::CmdRow: begin
        job.kind = hpf_pkg::KindRow;
        keep     = (in_i.row_select != 2'd3);
      end
      default: keep = 1'b0;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = slot_q[rd_q];
  assign do_push     = push_i && !full_o && keep;
  assign do_pop      = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= job;
  end

endmodule

[hw/rtl/hpf_back.sv]
// Back end: velocity window, PD law, direction matrix, norm clamp and means.
// Shares one 32x32 multiplier, one matrix multiplier, a sqrt and three divider lanes;
// the means use three reciprocal multipliers. Depends on hpf_pkg.
module hpf_back #(
  parameter int unsigned WINDOW = hpf_pkg::WindowDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hpf_pkg::cfg_t      cfg_i,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  hpf_pkg::job_t      job_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output hpf_pkg::out_item_t res_o
);

  localparam int unsigned PtrW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW = $clog2(WINDOW + 1);
  // ceil(2^32 / WINDOW): exact quotient for any dividend below 2^26.
  localparam logic [63:0] RecipW = ((64'd1 << 32) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StWin   = 12'b000000000010,
    StGain  = 12'b000000000100,
    StMat   = 12'b000000001000,
    StNorm  = 12'b000000010000,
    StShift = 12'b000000100000,
    StSq    = 12'b000001000000,
    StSqrt  = 12'b000010000000,
    StGl    = 12'b000100000000,
    StDiv   = 12'b001000000000,
    StMean  = 12'b010000000000,
    StOut   = 12'b100000000000
  } st_e;

  st_e st_q, st_d;
  logic [5:0]      cnt_q;
  logic [PtrW-1:0] ptr_q;
  logic [CntW-1:0] count_q;

  logic signed [39:0] sum_q   [3];
  logic signed [31:0] proxy_q [3];
  logic signed [17:0] mat_q   [3][3];

  logic [2:0][31:0]   win_mem [WINDOW];
  logic [2:0][31:0]   win_rd_q;

  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [32:0] e_q   [3];
  logic signed [41:0] u_q   [3];
  logic signed [61:0] acc_q [3];
  logic [45:0]        a_q   [3];
  logic               fneg_q [3];
  logic [31:0]        fl_q  [3];
  logic               sflag_q, clamp_q;
  logic [49:0]        ssum_q, sx_q, sres_q, sbit_q;
  logic [47:0]        dq_q  [3];
  logic [24:0]        rm_q  [3];
  logic [24:0]        dv_q;
  logic [57:0]        mp_q   [3];
  logic [19:0]        mqh_q  [3];
  logic [5:0]         mrem_q [3];
  logic [31:0]        force_q [3];
  logic [31:0]        mean_q  [3];

  logic [63:0]        prod_q;
  logic [39:0]        hiadd_q;
  logic               neg_q;
  logic [1:0]         tj_q;
  logic signed [59:0] mprod_q;
  logic [1:0]         ir_q, ic_q, tr_q;

  logic [31:0] pa, pb;
  logic [1:0]  gl;
  logic [32:0] e_mag;
  logic [31:0] v_mag;
  logic        win_full, big, clamp_now, div_last;
  logic [40:0] gr;
  logic [50:0] sq_t;
  logic        sq_ge;
  logic [24:0] root;
  logic [47:0] nq [3];
  logic [24:0] nr [3];
  logic [39:0] sum_mag [3];
  logic [25:0] mop [3];
  logic [39:0] mmag [3];
  logic signed [61:0] accb [3];
  logic signed [45:0] f46 [3];

  assign win_full  = (count_q == CntW'(WINDOW));
  assign big       = (|a_q[0][45:24]) || (|a_q[1][45:24]) || (|a_q[2][45:24]);
  assign clamp_now = sflag_q || (ssum_q > {2'b00, prod_q[47:0]});
  assign div_last  = (st_q == StDiv) && (cnt_q == 6'd47);
  assign gr        = {1'b0, prod_q[63:24]} + {1'b0, hiadd_q};
  assign sq_t      = {1'b0, sres_q} + {1'b0, sbit_q};
  assign sq_ge     = ({1'b0, sx_q} >= sq_t);
  assign root      = (sres_q == '0) ? 25'd1 : sres_q[24:0];

  // Operand selection for the shared 32x32 multiplier.
  always_comb begin
    gl    = (cnt_q < 6'd3) ? cnt_q[1:0] : 2'(cnt_q - 6'd3);
    e_mag = e_q[gl][32] ? 33'(-e_q[gl]) : 33'(e_q[gl]);
    v_mag = vel_q[gl][31] ? 32'(-vel_q[gl]) : 32'(vel_q[gl]);
    pa    = '0;
    pb    = '0;
    if (st_q == StGain) begin
      pa = (cnt_q < 6'd3) ? e_mag[31:0] : v_mag;
      pb = (cnt_q < 6'd3) ? cfg_i.stiffness_gain : cfg_i.damping_gain;
    end else if (st_q == StSq) begin
      pa = (cnt_q < 6'd3) ? {8'b0, a_q[cnt_q[1:0]][23:0]} : {8'b0, cfg_i.force_limit};
      pb = pa;
    end else if (st_q == StGl) begin
      pa = {8'b0, a_q[cnt_q[1:0]][23:0]};
      pb = {8'b0, cfg_i.force_limit};
    end
  end

  // Divider lanes, one quotient bit per cycle; norm prep, magnitudes and the
  // two digits of the mean: high 20 bits first, then remainder and low 20 bits.
  always_comb begin
    logic [25:0] sh;
    logic        ge;
    for (int i = 0; i < 3; i++) begin
      sh         = {rm_q[i], dq_q[i][47]};
      ge         = (sh >= {1'b0, dv_q});
      nr[i]      = ge ? 25'(sh - {1'b0, dv_q}) : sh[24:0];
      nq[i]      = {dq_q[i][46:0], ge};
      sum_mag[i] = sum_q[i][39] ? 40'(-sum_q[i]) : 40'(sum_q[i]);
      mop[i]     = (cnt_q == 6'd0) ? {6'b0, sum_mag[i][39:20]}
                                   : {mrem_q[i], sum_mag[i][19:0]};
      mmag[i]    = {mqh_q[i], mp_q[i][51:32]};
      accb[i]    = acc_q[i] + (acc_q[i][61] ? 62'sd65535 : 62'sd0);
      f46[i]     = 46'(accb[i] >>> 16);
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (job_valid_i && job_i.kind == hpf_pkg::KindTick) st_d = StWin;
      StWin:   st_d = StGain;
      StGain:  if (cnt_q == 6'd6) st_d = StMat;
      StMat:   if (cnt_q == 6'd9) st_d = StNorm;
      StNorm:  st_d = StShift;
      StShift: if (!big) st_d = StSq;
      StSq:    if (cnt_q == 6'd4) st_d = clamp_now ? StSqrt : StMean;
      StSqrt:  if (sbit_q[0]) st_d = StGl;
      StGl:    if (cnt_q == 6'd3) st_d = StDiv;
      StDiv:   if (div_last) st_d = StMean;
      StMean:  if (cnt_q == 6'd3) st_d = StOut;
      StOut:   if (res_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign job_ready_o = (st_q == StIdle);
  assign res_valid_o = (st_q == StOut);

  always_comb begin
    res_o.force_x    = force_q[0];
    res_o.force_y    = force_q[1];
    res_o.force_z    = force_q[2];
    res_o.mean_vel_x = mean_q[0];
    res_o.mean_vel_y = mean_q[1];
    res_o.mean_vel_z = mean_q[2];
    res_o.clamped    = clamp_q;
  end

  // State that reset defines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      cnt_q   <= '0;
      ptr_q   <= '0;
      count_q <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i]   <= '0;
        proxy_q[i] <= '0;
        for (int j = 0; j < 3; j++) mat_q[i][j] <= '0;
      end
    end else begin
      st_q  <= st_d;
      cnt_q <= (st_d != st_q || div_last) ? 6'd0 : cnt_q + 6'd1;
      if (st_q == StIdle && job_valid_i) begin
        if (job_i.kind == hpf_pkg::KindProxy) begin
          for (int i = 0; i < 3; i++) proxy_q[i] <= $signed(job_i.first[i]);
        end else if (job_i.kind == hpf_pkg::KindRow) begin
          for (int j = 0; j < 3; j++) mat_q[job_i.row][j] <= $signed(job_i.first[j][17:0]);
        end
      end
      if (st_q == StWin) begin
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= sum_q[i] + 40'(vel_q[i])
                      - (win_full ? 40'($signed(win_rd_q[i])) : 40'sd0);
        end
        ptr_q <= (ptr_q == PtrW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
        if (!win_full) count_q <= count_q + 1'b1;
      end
    end
  end

  // Velocity window memory, registered read at the write pointer.
  always_ff @(posedge clk_i) begin
    if (st_q == StWin) win_mem[ptr_q] <= {vel_q[2], vel_q[1], vel_q[0]};
    win_rd_q <= win_mem[ptr_q];
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    prod_q  <= pa * pb;
    hiadd_q <= (st_q == StGain && cnt_q < 6'd3 && e_mag[32])
               ? {cfg_i.stiffness_gain, 8'b0} : 40'b0;
    neg_q   <= (cnt_q < 6'd3) ? e_q[gl][32] : vel_q[gl][31];
    tj_q    <= gl;
    mprod_q <= mat_q[ir_q][ic_q] * u_q[ic_q];
    tr_q    <= ir_q;
    for (int i = 0; i < 3; i++) mp_q[i] <= mop[i] * RecipW[31:0];
    unique case (st_q)
      StIdle: begin
        for (int i = 0; i < 3; i++) begin
          pos_q[i] <= $signed(job_i.first[i]);
          vel_q[i] <= $signed(job_i.vel[i]);
          u_q[i]   <= '0;
          acc_q[i] <= '0;
        end
      end
      StWin: begin
        for (int i = 0; i < 3; i++) e_q[i] <= 33'(pos_q[i]) - 33'(proxy_q[i]);
        ir_q <= 2'd0;
        ic_q <= 2'd0;
      end
      StGain: begin
        // Subtract each gain term from its lane in the cycle after it is issued.
        if (cnt_q != 6'd0) begin
          u_q[tj_q] <= neg_q ? u_q[tj_q] + $signed({1'b0, gr})
                             : u_q[tj_q] - $signed({1'b0, gr});
        end
      end
      StMat: begin
        if (ic_q == 2'd2) begin
          ic_q <= 2'd0;
          ir_q <= ir_q + 2'd1;
        end else begin
          ic_q <= ic_q + 2'd1;
        end
        if (cnt_q != 6'd0) acc_q[tr_q] <= acc_q[tr_q] + 62'(mprod_q);
      end
      StNorm: begin
        for (int i = 0; i < 3; i++) begin
          fneg_q[i] <= f46[i][45];
          a_q[i]    <= f46[i][45] ? 46'(-f46[i]) : 46'(f46[i]);
          fl_q[i]   <= f46[i][31:0];
        end
        sflag_q <= 1'b0;
        ssum_q  <= '0;
      end
      StShift: begin
        if (big) begin
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
          sflag_q <= 1'b1;
        end
      end
      StSq: begin
        if (cnt_q != 6'd0 && cnt_q != 6'd4) ssum_q <= ssum_q + {2'b00, prod_q[47:0]};
        if (cnt_q == 6'd4) begin
          clamp_q <= clamp_now;
          sx_q    <= ssum_q;
          sres_q  <= '0;
          sbit_q  <= {2'b01, 48'b0};
          if (!clamp_now) begin
            for (int i = 0; i < 3; i++) force_q[i] <= fl_q[i];
          end
        end
      end
      StSqrt: begin
        if (sq_ge) begin
          sx_q   <= 50'(sx_q - sq_t[49:0]);
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      StGl: begin
        if (cnt_q != 6'd0) begin
          dq_q[2'(cnt_q - 6'd1)] <= prod_q[47:0];
          rm_q[2'(cnt_q - 6'd1)] <= '0;
        end
        dv_q <= root;
      end
      StDiv: begin
        for (int i = 0; i < 3; i++) begin
          dq_q[i] <= nq[i];
          rm_q[i] <= nr[i];
        end
        if (div_last) begin
          // Store the scaled force with its sign restored.
          for (int i = 0; i < 3; i++) begin
            force_q[i] <= fneg_q[i] ? 32'(-nq[i]) : nq[i][31:0];
          end
        end
      end
      StMean: begin
        // High digit quotient and remainder, then the low digit quotient.
        if (cnt_q == 6'd1) begin
          for (int i = 0; i < 3; i++) begin
            mqh_q[i]  <= mp_q[i][51:32];
            mrem_q[i] <= 6'(sum_mag[i][39:20] - 20'(mp_q[i][51:32] * 20'(WINDOW)));
          end
        end
        if (cnt_q == 6'd3) begin
          for (int i = 0; i < 3; i++) begin
            mean_q[i] <= sum_q[i][39] ? 32'(-mmag[i]) : mmag[i][31:0];
          end
        end
      end
      StOut: ;
      default: ;
    endcase
  end

endmodule

[hw/rtl/hpf_outq.sv]
// Result queue: two entries between the back end and the result port.
// Depends on hpf_pkg.
module hpf_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  output logic               res_ready_o,
  input  hpf_pkg::out_item_t res_i,
  output logic               empty_o,
  input  logic               pop_i,
  output hpf_pkg::out_item_t res_o
);

  hpf_pkg::out_item_t slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign res_ready_o = (cnt_q != 2'd2);
  assign empty_o     = (cnt_q == 2'd0);
  assign res_o       = slot_q[rd_q];
  assign do_push     = res_valid_i && res_ready_o;
  assign do_pop      = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= res_i;
  end

endmodule

[hw/rtl/haptic_pd_force_with_norm_clamp.sv]
// Haptic PD force loop with vector-norm clamp and windowed velocity mean.
// Each tick passes the normalizing shift; a clamped tick also passes the sqrt
// and the bit-serial force divider. Ticks are worked one at a time, and a new
// tick is taken only once the last result has entered the result queue; proxy
// and row beats are applied while the back end is idle. Reset (async, active low)
// clears gains, matrix, proxy, window sum and queues.
module haptic_pd_force_with_norm_clamp #(
  parameter int unsigned WINDOW = hpf_pkg::WindowDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  hpf_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output hpf_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  hpf_pkg::cfg_t      cfg_q;
  hpf_pkg::job_t      job;
  logic               job_valid, job_ready;
  hpf_pkg::out_item_t res;
  logic               res_valid, res_ready;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hpf_pkg::CfgStiffness: cfg_q.stiffness_gain <= cfg_data_i;
        hpf_pkg::CfgDamping:   cfg_q.damping_gain   <= cfg_data_i;
        hpf_pkg::CfgLimit:     cfg_q.force_limit    <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Front: take beats, drop the ones that do nothing, queue the rest.
  hpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_i        (in_item_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // Back: apply updates and run the force computation for each tick.
  hpf_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Hold finished results until the consumer pops them.
  hpf_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (out_item_o)
  );

endmodule
